@@ rtl/assert_macros.svh @@
// Assertion macros shared by the checker files.
// Needs signals named clk and rst_n in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off during reset
`define ASSERT_IMP(lbl, ant, con) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (con)) \
    else $error("assertion failed");

// Next-cycle implication, off during reset
`define ASSERT_NXT(lbl, ant, con) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (con)) \
    else $error("assertion failed");

// Next-cycle implication, checked during reset as well
`define ASSERT_NXT_RST(lbl, ant, con) \
  lbl: assert property (@(posedge clk) (ant) |=> (con)) \
    else $error("assertion failed");

`endif

@@ rtl/hkpl_pkg.sv @@
// Types, constants and command/status structs for the held key priority list.
// No dependencies; imported by every module of the block.
package hkpl_pkg;

  localparam int LIST_DEPTH = 8;
  localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
  localparam int IDX_W      = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int KEY_W      = 8;
  localparam int HELD_W     = 4;

  typedef struct packed {
    logic [KEY_W-1:0] key_code;
    logic             key_held;
    logic             scan_end;
  } hkpl_in_t;

  typedef struct packed {
    logic [KEY_W-1:0]  newest_key;
    logic [HELD_W-1:0] held_count;
    logic              list_empty;
  } hkpl_out_t;

  typedef enum logic [1:0] {
    RD_CUR,
    RD_PREV,
    RD_NEXT
  } hkpl_rd_sel_t;

  typedef struct packed {
    logic         load;
    logic         search_step;
    logic         start_ins;
    logic         shift_ins;
    logic         write_front;
    logic         shift_rem;
    logic         drop_entry;
    logic         finish;
    hkpl_rd_sel_t rd_sel;
  } hkpl_cmd_t;

  typedef struct packed {
    logic hit;
    logic search_done;
    logic held;
    logic idx_zero;
    logic rem_last;
  } hkpl_sts_t;

endpackage

@@ rtl/hkpl_dpath.sv @@
// Datapath: key list registers, walk index, count, scan flag and result word.
// Depends on hkpl_pkg; driven by hkpl_ctrl through hkpl_cmd_t.
module hkpl_dpath import hkpl_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  hkpl_in_t  in_data,
  input  hkpl_cmd_t cmd,
  output hkpl_sts_t sts,
  output hkpl_out_t out_data
);

  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(LIST_DEPTH);
  localparam logic [CNT_W-1:0] ONE_C   = CNT_W'(1);

  hkpl_in_t         item_r;
  logic [KEY_W-1:0] key_list_r [LIST_DEPTH];
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] idx_r;
  logic             saw_held_r;
  hkpl_out_t        out_r;

  logic [CNT_W-1:0] rd_idx;
  logic [KEY_W-1:0] rd_data;
  logic [CNT_W:0]   idx_inc;
  logic             saw_nxt;
  logic             clear;
  logic [CNT_W-1:0] cnt_fin;

  always_comb begin
    case (cmd.rd_sel)
      RD_PREV: rd_idx = idx_r - ONE_C;
      RD_NEXT: rd_idx = idx_r + ONE_C;
      default: rd_idx = idx_r;
    endcase
  end

  assign rd_data = key_list_r[rd_idx[IDX_W-1:0]];
  assign idx_inc = {1'b0, idx_r} + (CNT_W+1)'(1);

  assign sts.hit         = (rd_data == item_r.key_code);
  assign sts.search_done = (idx_r >= count_r);
  assign sts.held        = item_r.key_held;
  assign sts.idx_zero    = (idx_r == '0);
  assign sts.rem_last    = (idx_inc >= {1'b0, count_r});

  assign saw_nxt = saw_held_r | item_r.key_held;
  assign clear   = item_r.scan_end & ~saw_nxt;
  assign cnt_fin = clear ? '0 : count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= '0;
      saw_held_r <= 1'b0;
      idx_r      <= '0;
    end else begin
      if (cmd.load) begin
        idx_r <= '0;
      end
      if (cmd.search_step || cmd.shift_rem) begin
        idx_r <= idx_r + ONE_C;
      end
      if (cmd.start_ins) begin
        idx_r <= (count_r >= DEPTH_C) ? DEPTH_C - ONE_C : count_r;
      end
      if (cmd.shift_ins) begin
        idx_r <= idx_r - ONE_C;
      end
      if (cmd.write_front) begin
        count_r <= (count_r >= DEPTH_C) ? DEPTH_C : count_r + ONE_C;
      end
      if (cmd.drop_entry) begin
        count_r <= count_r - ONE_C;
      end
      if (cmd.finish) begin
        count_r    <= cnt_fin;
        saw_held_r <= item_r.scan_end ? 1'b0 : saw_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= in_data;
    end
    if (cmd.shift_ins || cmd.shift_rem) begin
      key_list_r[idx_r[IDX_W-1:0]] <= rd_data;
    end
    if (cmd.write_front) begin
      key_list_r[0] <= item_r.key_code;
    end
    if (cmd.finish) begin
      out_r.newest_key <= (cnt_fin != '0) ? key_list_r[0] : '0;
      out_r.held_count <= HELD_W'(cnt_fin);
      out_r.list_empty <= (cnt_fin == '0);
    end
  end

  assign out_data = out_r;

endmodule

@@ rtl/hkpl_ctrl.sv @@
// Controller: sequences search, insert shift and remove shift over the list.
// Depends on hkpl_pkg; commands hkpl_dpath and owns both handshakes.
module hkpl_ctrl import hkpl_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  hkpl_sts_t sts,
  output hkpl_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_INS,
    S_REM,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_SEARCH;
        end
      end
      S_SEARCH: begin
        cmd.rd_sel = RD_CUR;
        if (sts.search_done) begin
          if (sts.held) begin
            cmd.start_ins = 1'b1;
            state_nxt     = S_INS;
          end else begin
            state_nxt = S_DONE;
          end
        end else if (sts.hit) begin
          state_nxt = sts.held ? S_DONE : S_REM;
        end else begin
          cmd.search_step = 1'b1;
        end
      end
      S_INS: begin
        cmd.rd_sel = RD_PREV;
        if (sts.idx_zero) begin
          cmd.write_front = 1'b1;
          state_nxt       = S_DONE;
        end else begin
          cmd.shift_ins = 1'b1;
        end
      end
      S_REM: begin
        cmd.rd_sel = RD_NEXT;
        if (sts.rem_last) begin
          cmd.drop_entry = 1'b1;
          state_nxt      = S_DONE;
        end else begin
          cmd.shift_rem = 1'b1;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.finish) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

@@ rtl/held_key_priority_list_core.sv @@
// Held key list, newest first, up to LIST_DEPTH entries: each accepted word is one scan
// slot and returns one word with the newest key, the count and an empty flag. An item's
// time is set by the search walk over the list and the shift walk on insert or removal,
// one entry per cycle through a single list read port. The next word is taken while the
// previous result waits at the output.
module held_key_priority_list_core import hkpl_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  hkpl_in_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output hkpl_out_t out_data
);

  hkpl_cmd_t cmd;
  hkpl_sts_t sts;

  hkpl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  hkpl_dpath u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule

@@ rtl/hkpl_checker.sv @@
// Port-level checks for held_key_priority_list_core, bound to the top level.
// Depends on hkpl_pkg and assert_macros.svh.
`include "assert_macros.svh"

module hkpl_checker import hkpl_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input hkpl_out_t out_data
);

  `ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))
  `ASSERT_IMP(a_empty_word, out_valid && out_data.list_empty, out_data.held_count == '0 && out_data.newest_key == '0)
  `ASSERT_IMP(a_count_range, out_valid, out_data.held_count <= HELD_W'(LIST_DEPTH))
  `ASSERT_NXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
  `ASSERT_NXT_RST(a_reset_quiet, !rst_n, !out_valid && in_ready)

endmodule

bind held_key_priority_list_core hkpl_checker u_hkpl_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

@@ tb/tb_held_key_priority_list_core.sv @@
// Self-checking testbench for held_key_priority_list_core: drives key scan slots
// and checks every status word against a model of the held key list kept here
// or a directed row's expected word. Depends on hkpl_pkg and the core RTL only.
`timescale 1ns / 1ps

module tb_held_key_priority_list_core;
  import hkpl_pkg::*;

  localparam int NUM_SLOTS  = 1050;
  localparam int IDLE_LIMIT = 3000;
  localparam int LONG_HOLD  = 400;
  localparam int POOL_MAX   = 12;
  localparam int IN_W       = $bits(hkpl_in_t);

  typedef struct {
    hkpl_in_t  slot;
    bit        typed;
    hkpl_out_t want;
  } slot_row_t;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  hkpl_in_t  in_data;
  logic      out_valid;
  logic      out_ready;
  hkpl_out_t out_data;

  logic [KEY_W-1:0] held_keys [LIST_DEPTH];
  int               held_n;
  bit               scan_held;

  hkpl_out_t due_status [$];
  hkpl_out_t want_word;
  int        errors;
  int        sent;
  int        idle_cycles;
  bit        tx_burst;
  bit        rx_burst;
  bit        long_hold;
  bit        long_hold_done;

  held_key_priority_list_core u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  function automatic hkpl_out_t track_slot(input hkpl_in_t s);
    int        pos;
    int        n;
    hkpl_out_t r;
    pos = -1;
    for (int i = 0; i < held_n; i++) begin
      if (pos < 0 && held_keys[i] == s.key_code) pos = i;
    end
    if (s.key_held) begin
      if (pos < 0) begin
        n = (held_n >= LIST_DEPTH) ? LIST_DEPTH - 1 : held_n;
        for (int i = n; i > 0; i--) held_keys[i] = held_keys[i-1];
        held_keys[0] = s.key_code;
        held_n = n + 1;
      end
      scan_held = 1'b1;
    end else if (pos >= 0) begin
      for (int i = pos; i + 1 < held_n; i++) held_keys[i] = held_keys[i+1];
      held_n--;
    end
    if (s.scan_end) begin
      if (!scan_held) held_n = 0;
      scan_held = 1'b0;
    end
    r.newest_key = (held_n > 0) ? held_keys[0] : '0;
    r.held_count = held_n[HELD_W-1:0];
    r.list_empty = (held_n == 0);
    return r;
  endfunction

  function automatic slot_row_t mk_row(input int key, input bit held, input bit last,
                                       input bit typed, input int nk, input int cnt,
                                       input bit emp);
    slot_row_t r;
    r.slot.key_code   = key[KEY_W-1:0];
    r.slot.key_held   = held;
    r.slot.scan_end   = last;
    r.typed           = typed;
    r.want.newest_key = nk[KEY_W-1:0];
    r.want.held_count = cnt[HELD_W-1:0];
    r.want.list_empty = emp;
    return r;
  endfunction

  task automatic offer_slot(input hkpl_in_t slot, input bit typed, input hkpl_out_t want,
                            input bit drain);
    int        gap;
    bit        lower;
    hkpl_out_t got;
    gap   = tx_burst ? 0 : $urandom_range(0, 5);
    lower = (gap > 0) || (drain && due_status.size() != 0);
    if (lower) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      while (drain && due_status.size() != 0) @(posedge clk);
    end
    in_data <= slot;
    if (in_valid !== 1'b1) in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    got = track_slot(slot);
    due_status.push_back(typed ? want : got);
    sent++;
    if (sent == 400) long_hold = 1'b1;
    if ($urandom_range(0, 39) == 0) tx_burst = !tx_burst;
  endtask

  // result side: draw a stall per word, hold off once for a long stretch
  initial begin
    int gap;
    wait (rst_n === 1'b1);
    forever begin
      gap = rx_burst ? 0 : $urandom_range(0, 5);
      if (long_hold && !long_hold_done) begin
        gap = LONG_HOLD;
        long_hold_done = 1'b1;
      end
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      if (out_ready !== 1'b1) out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      if ($urandom_range(0, 39) == 0) rx_burst = !rx_burst;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (due_status.size() == 0) begin
        $error("result word with no status due");
        errors++;
      end else begin
        want_word = due_status.pop_front();
        if (out_data.newest_key !== want_word.newest_key) begin
          $error("newest_key: expected %0d, got %0d", want_word.newest_key,
                 out_data.newest_key);
          errors++;
        end
        if (out_data.held_count !== want_word.held_count) begin
          $error("held_count: expected %0d, got %0d", want_word.held_count,
                 out_data.held_count);
          errors++;
        end
        if (out_data.list_empty !== want_word.list_empty) begin
          $error("list_empty: expected %0d, got %0d", want_word.list_empty,
                 out_data.list_empty);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin
    slot_row_t        rows [$];
    logic [KEY_W-1:0] pool_keys [POOL_MAX];
    bit               pressed [POOL_MAX];
    int               pool_n;
    hkpl_in_t         slot;
    hkpl_out_t        none;

    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    out_ready   = 1'b0;
    errors      = 0;
    sent        = 0;
    idle_cycles = 0;
    held_n      = 0;
    scan_held   = 1'b0;
    none        = '0;
    pool_n      = 0;

    rows.push_back(mk_row(0,   0, 0, 1, 0,   0, 1));
    rows.push_back(mk_row(255, 1, 0, 1, 255, 1, 0));
    rows.push_back(mk_row(0,   1, 0, 1, 0,   2, 0));
    rows.push_back(mk_row(255, 1, 0, 0, 0,   0, 0));
    for (int k = 1; k <= 6; k++) rows.push_back(mk_row(k, 1, 0, 0, 0, 0, 0));
    rows.push_back(mk_row(7,   1, 0, 1, 7,   LIST_DEPTH, 0));
    rows.push_back(mk_row(255, 0, 0, 0, 0,   0, 0));
    rows.push_back(mk_row(3,   0, 0, 0, 0,   0, 0));
    rows.push_back(mk_row(0,   0, 0, 0, 0,   0, 0));
    rows.push_back(mk_row(7,   0, 0, 0, 0,   0, 0));
    rows.push_back(mk_row(200, 1, 1, 0, 0,   0, 0));
    rows.push_back(mk_row(9,   0, 1, 1, 0,   0, 1));
    rows.push_back(mk_row(10,  1, 1, 1, 10,  1, 0));
    rows.push_back(mk_row(10,  1, 0, 0, 0,   0, 0));
    rows.push_back(mk_row(11,  0, 1, 0, 0,   0, 0));
    rows.push_back(mk_row(12,  0, 1, 1, 0,   0, 1));
    rows.push_back(mk_row(10,  0, 0, 0, 0,   0, 0));

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) offer_slot(rows[i].slot, rows[i].typed, rows[i].want, 1'b0);

    // scans over a pool of keys whose held state drifts, with some noise slots
    while (sent < NUM_SLOTS) begin
      if (pool_n == 0 || $urandom_range(0, 19) == 0) begin
        pool_n = $urandom_range(1, POOL_MAX);
        for (int i = 0; i < POOL_MAX; i++) begin
          if ($urandom_range(0, 7) == 0) pool_keys[i] = $urandom_range(0, 1) ? '1 : '0;
          else pool_keys[i] = KEY_W'($urandom);
          pressed[i] = 1'($urandom_range(0, 1));
        end
      end
      for (int i = 0; i < pool_n; i++) begin
        if ($urandom_range(0, 5) == 0) pressed[i] = !pressed[i];
      end
      if ($urandom_range(0, 7) == 0) begin
        for (int i = 0; i < POOL_MAX; i++) pressed[i] = 1'b0;
      end
      for (int i = 0; i < pool_n; i++) begin
        if ($urandom_range(0, 14) == 0) begin
          slot = IN_W'($urandom_range(0, (1 << IN_W) - 1));
        end else begin
          slot.key_code = pool_keys[i];
          slot.key_held = pressed[i];
          slot.scan_end = (i == pool_n - 1);
        end
        offer_slot(slot, 1'b0, none, sent == 700);
      end
    end
    in_valid <= 1'b0;

    while (due_status.size() != 0) @(posedge clk);
    repeat (2 * LIST_DEPTH + 8) @(posedge clk);
    if (due_status.size() != 0) begin
      $error("%0d status words never arrived", due_status.size());
      errors++;
    end
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
